FILE: hw/rtl/pba_pkg.sv
// Shared types, constants and register codes of the pixelating block averager.
package pba_pkg;

  localparam int unsigned MaxWidthDefault  = 2048;
  localparam int unsigned MaxHeightDefault = 2048;

  localparam int unsigned CfgW   = 12;
  localparam int unsigned SumW   = 14;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ProdW  = 17;
  localparam int unsigned LumW   = 10;

  localparam logic [CfgW-1:0] FrameWidthReset  = 12'd640;
  localparam logic [CfgW-1:0] FrameHeightReset = 12'd480;
  localparam logic [1:0]      DownShiftReset   = 2'd2;
  localparam logic            UsePaletteReset  = 1'b0;

  localparam logic [ProdW-1:0] LumCoefRed   = 17'd165;
  localparam logic [ProdW-1:0] LumCoefGreen = 17'd324;
  localparam logic [ProdW-1:0] LumCoefBlue  = 17'd63;
  localparam logic [LumW-1:0]  LumOffset    = 10'd16;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DOWN_SHIFT   = 2'd2,
    REG_USE_PALETTE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0] block_col;
    logic [CoordW-1:0] block_row;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic              frame_done;
  } block_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SumW-1:0] blue;
    logic [SumW-1:0] green;
    logic [SumW-1:0] red;
  } sums_t;

  typedef struct packed {
    logic              live;
    logic              first;
    logic              result;
    logic              frame_done;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } pos_t;

  typedef struct packed {
    rgb_t              avg;
    logic              frame_done;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } avg_blk_t;

  localparam rgb_t Palette [4] = '{
    '{red: 8'h0F, green: 8'h38, blue: 8'h0F},
    '{red: 8'h30, green: 8'h61, blue: 8'h30},
    '{red: 8'h8A, green: 8'hAB, blue: 8'h0F},
    '{red: 8'hBB, green: 8'hCF, blue: 8'h5D}
  };

endpackage

FILE: hw/rtl/pba_raster.sv
// Raster position counters and block geometry of the incoming pixel.
module pba_raster #(
  parameter int unsigned MAX_WIDTH  = pba_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = pba_pkg::MaxHeightDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [pba_pkg::CfgW-1:0]            cfg_width_i,
  input  logic [pba_pkg::CfgW-1:0]            cfg_height_i,
  input  logic [1:0]                          cfg_shift_i,
  input  logic                                step_i,
  output pba_pkg::pos_t                       pos_o,
  output logic [$clog2(MAX_WIDTH/2)-1:0]      idx_o
);
  import pba_pkg::*;

  localparam int unsigned XCW   = $clog2(MAX_WIDTH);
  localparam int unsigned YCW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = XCW + 1;
  localparam int unsigned HW    = YCW + 1;
  localparam int unsigned XCMPW = (WW > CfgW) ? WW : CfgW;
  localparam int unsigned YCMPW = (HW > CfgW) ? HW : CfgW;
  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned IW    = $clog2(Depth);

  logic [XCW-1:0]   col_q, col_d;
  logic [YCW-1:0]   row_q, row_d;
  logic [XCMPW-1:0] fw_ext;
  logic [YCMPW-1:0] fh_ext;
  logic [WW-1:0]    width, bw, col_inc;
  logic [HW-1:0]    height, bh, row_inc;
  logic [1:0]       shift;
  logic [2:0]       mask;
  logic [XCW-1:0]   bx;
  logic [YCW-1:0]   by;
  logic             live, at_first, at_last;

  always_comb begin
    fw_ext = XCMPW'(cfg_width_i);
    fh_ext = YCMPW'(cfg_height_i);
    if (fw_ext == '0) begin
      width = WW'(1);
    end else if (fw_ext > XCMPW'(MAX_WIDTH)) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(fw_ext);
    end
    if (fh_ext == '0) begin
      height = HW'(1);
    end else if (fh_ext > YCMPW'(MAX_HEIGHT)) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(fh_ext);
    end

    shift = (cfg_shift_i == 2'd0) ? 2'd1 : cfg_shift_i;
    mask  = 3'((4'd1 << shift) - 4'd1);
    bx    = col_q >> shift;
    by    = row_q >> shift;
    bw    = width >> shift;
    bh    = height >> shift;

    live     = (WW'(bx) < bw) && (HW'(by) < bh);
    at_first = ((col_q[2:0] & mask) == 3'd0) && ((row_q[2:0] & mask) == 3'd0);
    at_last  = ((col_q[2:0] & mask) == mask) && ((row_q[2:0] & mask) == mask);

    pos_o.live       = live;
    pos_o.first      = at_first;
    pos_o.result     = live && at_last;
    pos_o.frame_done = (WW'(bx) == bw - WW'(1)) && (HW'(by) == bh - HW'(1));
    pos_o.col        = CoordW'(bx);
    pos_o.row        = CoordW'(by);

    if (bx >= XCW'(Depth)) begin
      idx_o = IW'(bx - XCW'(Depth));
    end else begin
      idx_o = IW'(bx);
    end

    col_inc = WW'(col_q) + WW'(1);
    row_inc = HW'(row_q) + HW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (col_inc >= width) begin
      col_d = '0;
      row_d = (row_inc >= height) ? '0 : YCW'(row_inc);
    end else begin
      col_d = XCW'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hw/rtl/pba_accum.sv
// Accumulator memory with read-modify-write, forwarding and block averaging.
module pba_accum #(
  parameter int unsigned DEPTH = pba_pkg::MaxWidthDefault / 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pba_pkg::pixel_t            pix_i,
  input  pba_pkg::pos_t              pos_i,
  input  logic [$clog2(DEPTH)-1:0]   idx_i,
  input  logic [1:0]                 shift_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output pba_pkg::avg_blk_t          res_o
);
  import pba_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  sums_t          mem [DEPTH];
  sums_t          rdata_q, fwd_q, base, sums_new;
  logic           fwd_hit_q;
  logic           s1_v_q, s2_v_q;
  pos_t           s1_pos_q;
  pixel_t         s1_pix_q;
  logic [IW-1:0]  s1_idx_q;
  avg_blk_t       s2_q;
  logic           accept, s2_free;
  logic [1:0]     shift;
  logic [2:0]     avg_sh;

  always_comb begin
    shift  = (shift_i == 2'd0) ? 2'd1 : shift_i;
    avg_sh = {shift, 1'b0};
    if (s1_pos_q.first) begin
      base = '0;
    end else if (fwd_hit_q) begin
      base = fwd_q;
    end else begin
      base = rdata_q;
    end
    sums_new.red   = base.red   + SumW'(s1_pix_q.pixel_red);
    sums_new.green = base.green + SumW'(s1_pix_q.pixel_green);
    sums_new.blue  = base.blue  + SumW'(s1_pix_q.pixel_blue);
  end

  assign s2_free     = !s2_v_q || res_ready_i;
  assign in_ready_o  = !s1_v_q || !s1_pos_q.result || s2_free;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = s2_v_q;
  assign res_o       = s2_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem[s1_idx_q] <= sums_new;
    end
    if (accept) begin
      rdata_q <= mem[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= accept && pos_i.live;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q && s1_pos_q.result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q  <= pos_i;
      s1_pix_q  <= pix_i;
      s1_idx_q  <= idx_i;
      fwd_hit_q <= s1_v_q && (s1_idx_q == idx_i);
      fwd_q     <= sums_new;
    end
    if (s2_free && s1_v_q && s1_pos_q.result) begin
      s2_q.avg.red   <= 8'(sums_new.red   >> avg_sh);
      s2_q.avg.green <= 8'(sums_new.green >> avg_sh);
      s2_q.avg.blue  <= 8'(sums_new.blue  >> avg_sh);
      s2_q.frame_done <= s1_pos_q.frame_done;
      s2_q.col        <= s1_pos_q.col;
      s2_q.row        <= s1_pos_q.row;
    end
  end

endmodule

FILE: hw/rtl/pba_quant.sv
// Color quantizer and output register: palette by luminance or 5-6-5 truncation.
module pba_quant (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               use_palette_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pba_pkg::avg_blk_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pba_pkg::block_t    out_o
);
  import pba_pkg::*;

  logic             out_v_q;
  block_t           out_q;
  logic [ProdW-1:0] prod_r, prod_g, prod_b;
  logic [LumW-1:0]  lum;
  logic [1:0]       sel;
  rgb_t             color;

  always_comb begin
    prod_r = ProdW'(in_i.avg.red)   * LumCoefRed;
    prod_g = ProdW'(in_i.avg.green) * LumCoefGreen;
    prod_b = ProdW'(in_i.avg.blue)  * LumCoefBlue;
    lum    = LumOffset + LumW'(prod_r >> 8) + LumW'(prod_g >> 8) + LumW'(prod_b >> 8);
    sel    = (lum[LumW-1:8] != '0) ? 2'd3 : lum[7:6];
    if (use_palette_i) begin
      color = Palette[sel];
    end else begin
      color.red   = in_i.avg.red   & 8'hF8;
      color.green = in_i.avg.green & 8'hFC;
      color.blue  = in_i.avg.blue  & 8'hF8;
    end
  end

  assign in_ready_o  = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_ready_o) begin
      out_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      out_q.block_col  <= in_i.col;
      out_q.block_row  <= in_i.row;
      out_q.out_red    <= color.red;
      out_q.out_green  <= color.green;
      out_q.out_blue   <= color.blue;
      out_q.frame_done <= in_i.frame_done;
    end
  end

endmodule

FILE: hw/rtl/pixelate_block_average_quantize.sv
// Top level of the pixelating block averager with color quantization.
//
// Pixels enter in raster order on the in_valid_i/in_ready_o channel, one beat
// per pixel. Square blocks of 2, 4 or 8 pixels on a side are summed in an
// accumulator memory with one entry per block column. The beat of the last
// pixel of a whole block produces one beat on the out_valid_o/out_ready_i
// channel carrying the block coordinates and its new color, registered in
// the accumulator stage, the averaging stage and the output register. Pixels
// of partial edge blocks produce no output beat. Throughput is one pixel per
// clock while in_ready_o is high: each pixel takes one read and one write of
// the accumulator memory, and a pixel that hits the entry being written in
// the same cycle takes the sum from a forwarding register. Reset clears the
// raster counters and all pipeline valids and restores the registers to 640
// by 480, block side 4, 5-6-5 mode. The memory needs no clearing; the first
// pixel of each block overwrites its entry. When the receiver stalls, the
// output beat holds and one more finished block waits behind it; pixels keep
// flowing until the pixel that finishes a third block reaches the accumulator
// stage, then in_ready_o drops. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while idle; the user, not the block, ensures it.
module pixelate_block_average_quantize #(
  parameter int unsigned MAX_WIDTH  = pba_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = pba_pkg::MaxHeightDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [pba_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pba_pkg::pixel_t          in_pix_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pba_pkg::block_t          out_blk_o
);
  import pba_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned IW    = $clog2(Depth);

  logic [CfgW-1:0] width_q, height_q;
  logic [1:0]      shift_q;
  logic            palette_q;
  logic            accept;
  pos_t            pos;
  logic [IW-1:0]   idx;
  logic            res_valid, res_ready;
  avg_blk_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= FrameWidthReset;
      height_q  <= FrameHeightReset;
      shift_q   <= DownShiftReset;
      palette_q <= UsePaletteReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q   <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q  <= cfg_data_i;
        REG_DOWN_SHIFT:   shift_q   <= cfg_data_i[1:0];
        REG_USE_PALETTE:  palette_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  pba_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cfg_shift_i  (shift_q),
    .step_i       (accept),
    .pos_o        (pos),
    .idx_o        (idx)
  );

  pba_accum #(
    .DEPTH (Depth)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_i       (in_pix_i),
    .pos_i       (pos),
    .idx_i       (idx),
    .shift_i     (shift_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pba_quant u_quant (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .use_palette_i (palette_q),
    .in_valid_i    (res_valid),
    .in_ready_o    (res_ready),
    .in_i          (res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_blk_o)
  );

endmodule

FILE: hw/rtl/pba_checker.sv
// Port-level assertions for the pixelating block averager and their bind.
module pba_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [1:0]               cfg_idx_i,
  input logic [pba_pkg::CfgW-1:0] cfg_data_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input pba_pkg::block_t          out_blk_o
);
  import pba_pkg::*;

  logic palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= UsePaletteReset;
    end else if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_USE_PALETTE)) begin
      palette_q <= cfg_data_i[0];
    end
  end

  a_reset_clears_out: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output beat valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_blk_o))
    else $error("stalled output beat changed");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output is empty");

  a_truncated_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !palette_q |->
      (out_blk_o.out_red[2:0] == 3'd0) && (out_blk_o.out_green[1:0] == 2'd0) &&
      (out_blk_o.out_blue[2:0] == 3'd0))
    else $error("5-6-5 color has low bits set");

  a_palette_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && palette_q |->
      ({out_blk_o.out_red, out_blk_o.out_green, out_blk_o.out_blue} == 24'h0F380F) ||
      ({out_blk_o.out_red, out_blk_o.out_green, out_blk_o.out_blue} == 24'h306130) ||
      ({out_blk_o.out_red, out_blk_o.out_green, out_blk_o.out_blue} == 24'h8AAB0F) ||
      ({out_blk_o.out_red, out_blk_o.out_green, out_blk_o.out_blue} == 24'hBBCF5D))
    else $error("palette mode produced a color outside the palette");

endmodule

bind pixelate_block_average_quantize pba_checker u_pba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_blk_o   (out_blk_o)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pixelating block averager with color quantization.
module tb_top;
  import pba_pkg::*;

  localparam int unsigned StoreDepth = MaxWidthDefault / 2;
  localparam int unsigned Never      = 32'hFFFF_FFFF;
  localparam int unsigned ItemGoal   = 1900;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 8;

  localparam int unsigned LumaBase  = 16;
  localparam int unsigned LumaRed   = 165;
  localparam int unsigned LumaGreen = 324;
  localparam int unsigned LumaBlue  = 63;

  localparam rgb_t ShadeDark   = 24'h0F380F;
  localparam rgb_t ShadeMid    = 24'h306130;
  localparam rgb_t ShadeLight  = 24'h8AAB0F;
  localparam rgb_t ShadeBright = 24'hBBCF5D;

  typedef enum int unsigned {
    PIX_NOISE,
    PIX_FLAT,
    PIX_EXTREME
  } pix_style_e;

  function automatic int unsigned effective_size(logic [CfgW-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  class block_scoreboard;
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    logic [1:0]      shift_reg;
    logic            palette_reg;
    int unsigned     col_pos;
    int unsigned     row_pos;
    sums_t           block_sums [StoreDepth];
    block_t          expected_blocks [$];
    int unsigned     noted_pixels;
    int unsigned     mismatches;
    bit              failed;

    function new();
      width_reg    = FrameWidthReset;
      height_reg   = FrameHeightReset;
      shift_reg    = DownShiftReset;
      palette_reg  = UsePaletteReset;
      col_pos      = 0;
      row_pos      = 0;
      noted_pixels = 0;
      mismatches   = 0;
      failed       = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgW-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        REG_DOWN_SHIFT:   shift_reg = data[1:0];
        REG_USE_PALETTE:  palette_reg = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t pix);
      int unsigned w, h, s, side, bw, bh, bx, by, u, v, lum;
      sums_t  acc;
      rgb_t   avg;
      rgb_t   color;
      block_t blk;
      noted_pixels++;
      w    = effective_size(width_reg, MaxWidthDefault);
      h    = effective_size(height_reg, MaxHeightDefault);
      s    = (shift_reg == 0) ? 1 : shift_reg;
      side = 1 << s;
      bw   = w >> s;
      bh   = h >> s;
      bx   = col_pos >> s;
      by   = row_pos >> s;
      u    = col_pos & (side - 1);
      v    = row_pos & (side - 1);
      if (bx < bw && by < bh) begin
        acc = (u == 0 && v == 0) ? '0 : block_sums[bx % StoreDepth];
        acc.red   = acc.red + pix.pixel_red;
        acc.green = acc.green + pix.pixel_green;
        acc.blue  = acc.blue + pix.pixel_blue;
        block_sums[bx % StoreDepth] = acc;
        if (u == side - 1 && v == side - 1) begin
          avg.red   = 8'(acc.red >> (2 * s));
          avg.green = 8'(acc.green >> (2 * s));
          avg.blue  = 8'(acc.blue >> (2 * s));
          if (palette_reg) begin
            lum = LumaBase + ((32'(avg.red) * LumaRed) >> 8)
                + ((32'(avg.green) * LumaGreen) >> 8) + ((32'(avg.blue) * LumaBlue) >> 8);
            if (lum < 64) color = ShadeDark;
            else if (lum < 128) color = ShadeMid;
            else if (lum < 192) color = ShadeLight;
            else color = ShadeBright;
          end else begin
            color.red   = avg.red & 8'hF8;
            color.green = avg.green & 8'hFC;
            color.blue  = avg.blue & 8'hF8;
          end
          blk.block_col  = CoordW'(bx);
          blk.block_row  = CoordW'(by);
          blk.out_red    = color.red;
          blk.out_green  = color.green;
          blk.out_blue   = color.blue;
          blk.frame_done = (bx == bw - 1 && by == bh - 1);
          expected_blocks.push_back(blk);
        end
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function string describe(block_t b);
      return $sformatf("col %0d row %0d color %02h%02h%02h done %0b", b.block_col,
                       b.block_row, b.out_red, b.out_green, b.out_blue, b.frame_done);
    endfunction

    function void note_error(string msg);
      mismatches++;
      failed = 1'b1;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        note_error({"Block beat with nothing expected: ", describe(got)});
        return;
      end
      want = expected_blocks.pop_front();
      if (got.block_col !== want.block_col || got.block_row !== want.block_row ||
          got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.frame_done !== want.frame_done) begin
        note_error({"Block mismatch: expected ", describe(want), ", got ", describe(got)});
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b1;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  pixel_t          in_pix_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  block_t          out_blk_o;

  block_scoreboard sb = new;
  int unsigned     sender_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_req = 0;

  pixelate_block_average_quantize dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blk_o   (out_blk_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[pixelate_block_average_quantize] ERROR");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_block(out_blk_o);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_pixel(input pixel_t pix);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_pix_i   <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(pix);
  endtask

  task automatic drain_blocks();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_blocks.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic set_frame(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                           input logic [1:0] shift, input logic pal);
    drain_blocks();
    put_reg(REG_FRAME_WIDTH, w);
    put_reg(REG_FRAME_HEIGHT, h);
    put_reg(REG_DOWN_SHIFT, CfgW'(shift));
    put_reg(REG_USE_PALETTE, CfgW'(pal));
    cfg_we_i <= 1'b0;
    case ($urandom_range(3))
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  task automatic send_two_blocks(input pixel_t left, input pixel_t right);
    repeat (2) begin
      send_pixel(left);
      send_pixel(left);
      send_pixel(right);
      send_pixel(right);
    end
  endtask

  task automatic send_frame(input pix_style_e style, input int unsigned hold_at,
                            input int unsigned pause_at);
    int unsigned total;
    rgb_t        base;
    pixel_t      pix;
    total = effective_size(sb.width_reg, MaxWidthDefault)
          * effective_size(sb.height_reg, MaxHeightDefault);
    base  = rgb_t'(24'($urandom));
    for (int unsigned i = 0; i < total; i++) begin
      case (style)
        PIX_FLAT: begin
          pix.pixel_red   = base.red ^ 8'($urandom_range(7));
          pix.pixel_green = base.green ^ 8'($urandom_range(7));
          pix.pixel_blue  = base.blue ^ 8'($urandom_range(7));
        end
        PIX_EXTREME: begin
          pix.pixel_red   = $urandom_range(1) ? 8'hFF : 8'h00;
          pix.pixel_green = $urandom_range(1) ? 8'hFF : 8'h00;
          pix.pixel_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: pix = pixel_t'(24'($urandom));
      endcase
      if (i == hold_at) hold_req = HoldCycles;
      if (i == pause_at) drain_blocks();
      send_pixel(pix);
    end
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] w;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_frame(12'd4, 12'd2, 2'd1, 1'b0);
    send_two_blocks(24'hFF00FF, 24'h00FF00);
    set_frame(12'd4, 12'd2, 2'd0, 1'b1);
    send_two_blocks(24'h1E1E1E, 24'h3C3C3C);
    set_frame(12'd4, 12'd2, 2'd1, 1'b1);
    send_two_blocks(24'h000000, 24'hFFFFFF);
    set_frame(12'd0, 12'd0, 2'd3, 1'b0);
    send_pixel(pixel_t'(24'($urandom)));
    send_pixel(pixel_t'(24'($urandom)));

    // With 2-pixel blocks every other pixel of an odd row finishes a block,
    // so a long receiver hold there backs the block up into its input.
    set_frame(12'd16, 12'd8, 2'd1, 1'b0);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_frame(PIX_NOISE, 20, Never);
    set_frame(12'd16, 12'd8, 2'd1, 1'b1);
    send_frame(PIX_NOISE, Never, 64);

    while (sb.noted_pixels < ItemGoal) begin
      w = ($urandom_range(9) == 0) ? CfgW'($urandom_range(25, 64)) : CfgW'($urandom_range(24));
      set_frame(w, CfgW'($urandom_range(16)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      repeat ($urandom_range(1, 3)) send_frame(pix_style_e'($urandom_range(2)), Never, Never);
    end

    drain_blocks();
    if (!sb.failed && sb.expected_blocks.size() == 0) begin
      $display("[pixelate_block_average_quantize] OK");
    end else begin
      $display("[pixelate_block_average_quantize] ERROR");
    end
    $finish;
  end

endmodule

FILE: pixelate_block_average_quantize.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_raster.sv
hw/rtl/pba_accum.sv
hw/rtl/pba_quant.sv
hw/rtl/pixelate_block_average_quantize.sv
hw/rtl/pba_checker.sv
verif/tb_top.sv
